// ----- hw/rtl/psg_pkg.sv -----
// ============================================================================
// psg_pkg - shared types and constants of the Poisson spike generator
// Action codes, register map indexes and fixed field widths.
// ============================================================================
package psg_pkg;

    // Width of the time_step register (dt), fixed by the register map
    localparam int TSTEP_W = 16;

    // Width of the action field carried in tuser
    localparam int ACT_W = 2;

    // Width of a register index in the register map
    localparam int REG_IDX_W = 3;

    // Kind of an input transaction
    typedef enum logic [ACT_W-1:0] {
        ACT_TICK     = 2'd0,
        ACT_REINIT   = 2'd1,
        ACT_INTERVAL = 2'd2
    } t_action;

    // Register map, one register per address slot
    typedef enum logic [REG_IDX_W-1:0] {
        REG_PROB     = 3'd0,
        REG_MIN_AMP  = 3'd1,
        REG_MAX_AMP  = 3'd2,
        REG_RST_LVL  = 3'd3,
        REG_RST_TICK = 3'd4,
        REG_REFR     = 3'd5,
        REG_TSTEP    = 3'd6
    } t_reg_idx;

endpackage

// ----- hw/rtl/psg_amp.sv -----
// ============================================================================
// psg_amp - spike amplitude draw
// lo + floor(r * (hi - lo) / 2^RAND_WIDTH), with r a Q0.RAND_WIDTH fraction.
// ============================================================================
module psg_amp #(
    parameter int AMP_WIDTH  = 16,
    parameter int RAND_WIDTH = 16
) (
    input  logic signed [AMP_WIDTH-1:0]  i_lo,
    input  logic signed [AMP_WIDTH-1:0]  i_hi,
    input  logic        [RAND_WIDTH-1:0] i_frac,
    output logic signed [AMP_WIDTH-1:0]  o_level
);

    localparam int SpanW = AMP_WIDTH + 1;
    localparam int ProdW = RAND_WIDTH + AMP_WIDTH + 2;

    logic signed [SpanW-1:0]      w_span;
    logic signed [RAND_WIDTH:0]   w_frac;
    logic signed [ProdW-1:0]      w_prod;
    logic signed [ProdW-1:0]      w_scaled;
    logic signed [SpanW-1:0]      w_ofs;
    logic signed [SpanW-1:0]      w_sum;

    // span may be negative; arithmetic shift gives the floor either way
    assign w_span   = SpanW'(i_hi) - SpanW'(i_lo);
    assign w_frac   = $signed({1'b0, i_frac});
    assign w_prod   = w_frac * w_span;
    assign w_scaled = w_prod >>> RAND_WIDTH;
    assign w_ofs    = w_scaled[SpanW-1:0];
    assign w_sum    = SpanW'(i_lo) + w_ofs;

    // result lies between the bounds, no saturation needed
    assign o_level  = w_sum[AMP_WIDTH-1:0];

endmodule

// ----- hw/rtl/poisson_spike_generator.sv -----
// ============================================================================
// poisson_spike_generator - random spike source with refractory period
// Tick, reinit and interval transactions in, one result transaction out each.
// ============================================================================
// One result transaction per input transaction, in order. The block takes one
// input transaction every clock cycle unless the result stream stalls. The
// path has two register stages, the input register and then the result
// register; a stall on the result stream holds both stages.
// The state update (last event time, stored interval, output level) is
// combinational through the refractory and window compares and the single
// amplitude multiplier, which sets the clock-rate limit. Ticks fire either in
// interval mode (stored interval not negative: fire when
// last_event + interval - now lies in [0, dt)) or in rate mode (fire when the
// probability register is at least 1.0 or exceeds the random fraction).
// Nothing fires while refractory_time > now - last_event. A fired tick records
// now as the last event and draws a level between min and max. Reinit loads the
// reset level, sets the last event to minus the refractory time and returns to
// rate mode. Result tuser bit 0 is the fired flag; event_time reads 0 when not
// fired. Configuration goes through the APB port and may only be written
// while no transaction is in flight. pready is tied high, no wait states.
// ============================================================================
module poisson_spike_generator #(
    parameter int TIME_WIDTH = 32,
    parameter int AMP_WIDTH  = 16,
    parameter int RAND_WIDTH = 16,
    localparam int InDataW   = ((2 * TIME_WIDTH + 1 + 2 * RAND_WIDTH + 7) / 8) * 8,
    localparam int OutDataW  = ((TIME_WIDTH + AMP_WIDTH + 7) / 8) * 8,
    localparam int PDataW    = ((TIME_WIDTH > 32) || (RAND_WIDTH + 1 > 32)) ? 64 : 32,
    localparam int PAddrW    = (PDataW == 64) ? 6 : 5
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,

    // input stream
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // now_time, interval_value, random_fire, random_amp (lowest bits first)
    input  logic [InDataW-1:0]          s_axis_tdata,
    // action
    input  logic [psg_pkg::ACT_W-1:0]   s_axis_tuser,

    // result stream
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // event_time, level (lowest bits first)
    output logic [OutDataW-1:0]         m_axis_tdata,
    // fired
    output logic [0:0]                  m_axis_tuser,

    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [PAddrW-1:0]           paddr,
    input  logic [PDataW-1:0]           pwdata,
    output logic [PDataW-1:0]           prdata,
    output logic                        pready
);

    import psg_pkg::*;

    localparam int T  = TIME_WIDTH;
    localparam int A  = AMP_WIDTH;
    localparam int R  = RAND_WIDTH;
    localparam int CW = T + 3;  // width for time differences

    // tdata field offsets
    localparam int NowLo  = 0;
    localparam int IvalLo = NowLo + T;
    localparam int RfLo   = IvalLo + T + 1;
    localparam int RaLo   = RfLo + R;

    // ---------------------------------------------------------------- config
    logic [R:0]            r_prob;
    logic signed [A-1:0]   r_min_amp;
    logic signed [A-1:0]   r_max_amp;
    logic signed [A-1:0]   r_rst_lvl;
    logic                  r_rst_tick;
    logic [T-1:0]          r_refr;
    logic [TSTEP_W-1:0]    r_tstep;

    logic                  w_cfg_wr;
    t_reg_idx              w_reg_idx;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel & penable & pwrite & pready;
    assign w_reg_idx = t_reg_idx'(paddr[PAddrW-1 -: REG_IDX_W]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prob     <= '0;
            r_min_amp  <= '0;
            r_max_amp  <= '0;
            r_rst_lvl  <= '0;
            r_rst_tick <= 1'b0;
            r_refr     <= '0;
            r_tstep    <= TSTEP_W'(1);
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_PROB:     r_prob     <= pwdata[R:0];
                REG_MIN_AMP:  r_min_amp  <= pwdata[A-1:0];
                REG_MAX_AMP:  r_max_amp  <= pwdata[A-1:0];
                REG_RST_LVL:  r_rst_lvl  <= pwdata[A-1:0];
                REG_RST_TICK: r_rst_tick <= pwdata[0];
                REG_REFR:     r_refr     <= pwdata[T-1:0];
                REG_TSTEP:    r_tstep    <= pwdata[TSTEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_PROB:     prdata = PDataW'(r_prob);
            REG_MIN_AMP:  prdata = PDataW'($unsigned(r_min_amp));
            REG_MAX_AMP:  prdata = PDataW'($unsigned(r_max_amp));
            REG_RST_LVL:  prdata = PDataW'($unsigned(r_rst_lvl));
            REG_RST_TICK: prdata = PDataW'(r_rst_tick);
            REG_REFR:     prdata = PDataW'(r_refr);
            REG_TSTEP:    prdata = PDataW'(r_tstep);
            default:      prdata = '0;
        endcase
    end

    // ---------------------------------------------------------- input stage
    logic                  r_in_vld;
    t_action               r_in_act;
    logic [T-1:0]          r_in_now;
    logic signed [T:0]     r_in_ival;
    logic [R-1:0]          r_in_rf;
    logic [R-1:0]          r_in_ra;

    logic                  r_out_vld;
    logic                  w_advance;

    // stage moves on when the result register is free or being drained
    assign w_advance     = r_in_vld & (~r_out_vld | m_axis_tready);
    assign s_axis_tready = ~r_in_vld | w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready & s_axis_tvalid) begin
            r_in_act  <= t_action'(s_axis_tuser);
            r_in_now  <= s_axis_tdata[NowLo +: T];
            r_in_ival <= $signed(s_axis_tdata[IvalLo +: T + 1]);
            r_in_rf   <= s_axis_tdata[RfLo +: R];
            r_in_ra   <= s_axis_tdata[RaLo +: R];
        end
    end

    // ---------------------------------------------------------------- state
    logic signed [T:0]     r_last;     // last spike time, signed
    logic signed [T:0]     r_ival;     // stored interval, negative = rate mode
    logic signed [A-1:0]   r_level;

    logic signed [T:0]     n_last;
    logic signed [T:0]     n_ival;
    logic signed [A-1:0]   n_level;

    logic signed [CW-1:0]  w_now;
    logic signed [CW-1:0]  w_since;
    logic signed [CW-1:0]  w_dist;
    logic                  w_refractory;
    logic                  w_win_hit;
    logic                  w_rate_hit;
    logic                  w_fire;
    logic signed [A-1:0]   w_amp;

    assign w_now   = $signed({3'b000, r_in_now});
    assign w_since = w_now - CW'(r_last);
    assign w_dist  = CW'(r_last) + CW'(r_ival) - w_now;

    assign w_refractory = $signed({3'b000, r_refr}) > w_since;
    assign w_win_hit    = ~w_dist[CW-1] & (w_dist < $signed(CW'(r_tstep)));
    // probability bit R set means at least 1.0
    assign w_rate_hit   = r_prob[R] | (r_prob > {1'b0, r_in_rf});

    assign w_fire = (r_in_act == ACT_TICK) & ~w_refractory
                  & (r_ival[T] ? w_rate_hit : w_win_hit);

    psg_amp #(
        .AMP_WIDTH  (A),
        .RAND_WIDTH (R)
    ) u_amp (
        .i_lo    (r_min_amp),
        .i_hi    (r_max_amp),
        .i_frac  (r_in_ra),
        .o_level (w_amp)
    );

    always_comb begin
        n_last  = r_last;
        n_ival  = r_ival;
        n_level = r_level;
        case (r_in_act)
            ACT_TICK: begin
                if (r_rst_tick) begin
                    n_level = r_rst_lvl;
                end
                if (w_fire) begin
                    n_last  = $signed({1'b0, r_in_now});
                    n_level = w_amp;
                end
            end
            ACT_REINIT: begin
                n_level = r_rst_lvl;
                n_last  = -$signed({1'b0, r_refr});
                n_ival  = '1;
            end
            ACT_INTERVAL: begin
                n_ival = r_in_ival;
            end
            default: ;  // unused code leaves the state alone
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last  <= '0;
            r_ival  <= '1;
            r_level <= '0;
        end else if (w_advance) begin
            r_last  <= n_last;
            r_ival  <= n_ival;
            r_level <= n_level;
        end
    end

    // --------------------------------------------------------- result stage
    logic                  r_out_fired;
    logic [T-1:0]          r_out_time;
    logic signed [A-1:0]   r_out_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_advance) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_fired <= w_fire;
            r_out_time  <= w_fire ? r_in_now : '0;
            r_out_level <= n_level;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = OutDataW'({r_out_level, r_out_time});
    assign m_axis_tuser  = r_out_fired;

endmodule

// ----- tb/poisson_spike_generator_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// poisson_spike_generator_tb - self-checking bench for the spike generator
// Drives tick, reinit and interval transactions with random idle gaps on both
// streams, predicts each result transaction from its own copy of the state
// and registers, and compares every field in order.
// ============================================================================
module poisson_spike_generator_tb;
    import psg_pkg::*;

    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;   // code the block ignores
    localparam int WATCHDOG_LIMIT = 500;              // cycles with no transaction
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 130;

    // one result transaction: fired flag, spike time, output level
    typedef struct {
        logic               fired;
        logic [31:0]        event_time;
        logic signed [15:0] level;
    } t_spike_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // now_time, interval_value, random_fire, random_amp (lowest bits first)
    logic [103:0] s_axis_tdata = '0;
    // action
    logic [1:0]   s_axis_tuser = '0;

    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // event_time, level (lowest bits first)
    logic [47:0]  m_axis_tdata;
    // fired
    logic [0:0]   m_axis_tuser;

    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [4:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    // bench copy of the register file, at reset values
    logic [16:0]        prob_cfg = '0;
    logic signed [15:0] min_amp_cfg = '0;
    logic signed [15:0] max_amp_cfg = '0;
    logic signed [15:0] rst_lvl_cfg = '0;
    logic               each_tick_cfg = 1'b0;
    logic [31:0]        refr_cfg = '0;
    logic [15:0]        tstep_cfg = 16'd1;

    // bench copy of the block state
    logic signed [33:0] last_spike_time = '0;
    logic signed [33:0] stored_isi = -34'sd1;     // negative: rate mode
    logic signed [15:0] level_state = '0;

    t_spike_res spike_results_q[$];   // results still owed by the block
    int fail_count = 0;
    int items_sent = 0;
    int idle_cycles = 0;
    logic steady_flow = 1'b0;         // both sides stop idling while set

    poisson_spike_generator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Spike predictor: advances the bench state by one accepted transaction
    // and returns the result the block must give for it. Times are widened to
    // 64 bits so the refractory and window compares are exact signed compares.
    // ------------------------------------------------------------------------
    function automatic t_spike_res predict_spike(input logic [1:0] action,
                                                 input logic [31:0] now_t,
                                                 input logic signed [32:0] isi,
                                                 input logic [15:0] rfire,
                                                 input logic [15:0] ramp);
        t_spike_res res;
        longint now_l, last_l, isi_l, gap_l, lo, hi, prod, amp;
        logic hit;
        hit = 1'b0;
        now_l = longint'({32'd0, now_t});
        last_l = last_spike_time;
        case (action)
            ACT_TICK: begin
                if (each_tick_cfg)
                    level_state = rst_lvl_cfg;
                // silent inside the refractory window
                if (!(longint'({32'd0, refr_cfg}) > now_l - last_l)) begin
                    isi_l = stored_isi;
                    if (isi_l >= 0) begin
                        // interval mode: hit when the due time lies in [now, now+dt)
                        gap_l = last_l + isi_l - now_l;
                        hit = (gap_l >= 0) && (gap_l < longint'({48'd0, tstep_cfg}));
                    end else begin
                        // rate mode: 1.0 and above always fires
                        hit = (prob_cfg >= 17'h10000) || (prob_cfg > {1'b0, rfire});
                    end
                    if (hit) begin
                        last_spike_time = now_l[33:0];
                        lo = min_amp_cfg;
                        hi = max_amp_cfg;
                        // floor of the scaled span, towards minus infinity
                        prod = longint'({48'd0, ramp}) * (hi - lo);
                        amp = lo + (prod >>> 16);
                        level_state = amp[15:0];
                    end
                end
            end
            ACT_REINIT: begin
                level_state = rst_lvl_cfg;
                last_spike_time = -34'(longint'({32'd0, refr_cfg}));
                stored_isi = -34'sd1;
            end
            ACT_INTERVAL: stored_isi = isi;
            default: ;
        endcase
        res.fired = hit;
        res.event_time = hit ? now_t : 32'd0;
        res.level = level_state;
        return res;
    endfunction

    function automatic int reg_width(input t_reg_idx idx);
        case (idx)
            REG_PROB:     return 17;
            REG_RST_TICK: return 1;
            REG_REFR:     return 32;
            REG_TSTEP:    return TSTEP_W;
            default:      return 16;
        endcase
    endfunction

    function automatic logic signed [32:0] rand_isi();
        return {1'($urandom_range(0, 1)), 32'($urandom)};
    endfunction

    // ------------------------------------------------------------------------
    // Stream driver: optional idle gap, then hold the transaction until taken.
    // tvalid is left high on acceptance so back-to-back items need no toggle.
    // ------------------------------------------------------------------------
    task automatic send_item(input logic [1:0] action, input logic [31:0] now_t,
                             input logic signed [32:0] isi, input logic [15:0] rfire,
                             input logic [15:0] ramp);
        if (!steady_flow) begin
            while ($urandom_range(0, 99) < 30) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= action;
        s_axis_tdata <= {7'd0, ramp, rfire, isi, now_t};
        do @(posedge i_clk); while (!s_axis_tready);
        spike_results_q.push_back(predict_spike(action, now_t, isi, rfire, ramp));
        if (action != ACT_UNUSED)
            items_sent++;
    endtask

    task automatic send_tick(input logic [31:0] now_t, input logic [15:0] rfire,
                             input logic [15:0] ramp);
        send_item(ACT_TICK, now_t, rand_isi(), rfire, ramp);
    endtask

    task automatic send_reinit();
        send_item(ACT_REINIT, $urandom, rand_isi(), 16'($urandom), 16'($urandom));
    endtask

    task automatic send_interval(input logic signed [32:0] isi);
        send_item(ACT_INTERVAL, $urandom, isi, 16'($urandom), 16'($urandom));
    endtask

    // stop sending and let every owed result come back before touching registers
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (spike_results_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // APB access. Readback ends with one bus idle cycle so that a following
    // access never lowers and raises psel in the same step.
    // ------------------------------------------------------------------------
    task automatic reg_readback(input t_reg_idx idx, input logic [31:0] want);
        logic [31:0] mask;
        mask = 32'((64'd1 << reg_width(idx)) - 64'd1);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if ((prdata & mask) !== (want & mask)) begin
            $display("%0t register %s readback: expected %h actual %h",
                     $time, idx.name(), want & mask, prdata & mask);
            fail_count++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic reg_write(input t_reg_idx idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_PROB:     prob_cfg = value[16:0];
            REG_MIN_AMP:  min_amp_cfg = value[15:0];
            REG_MAX_AMP:  max_amp_cfg = value[15:0];
            REG_RST_LVL:  rst_lvl_cfg = value[15:0];
            REG_RST_TICK: each_tick_cfg = value[0];
            REG_REFR:     refr_cfg = value;
            REG_TSTEP:    tstep_cfg = value[15:0];
            default: ;
        endcase
        reg_readback(idx, value);
    endtask

    // ------------------------------------------------------------------------
    // Test tasks
    // ------------------------------------------------------------------------

    // registers at reset; probability 0 never fires
    task automatic test_register_defaults();
        reg_readback(REG_PROB, 32'd0);
        reg_readback(REG_MIN_AMP, 32'd0);
        reg_readback(REG_MAX_AMP, 32'd0);
        reg_readback(REG_RST_LVL, 32'd0);
        reg_readback(REG_RST_TICK, 32'd0);
        reg_readback(REG_REFR, 32'd0);
        reg_readback(REG_TSTEP, 32'd1);
        send_tick(32'd0, 16'd0, 16'd0);
        send_tick(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    endtask

    // rate mode, amplitude extremes, saturation, ignored action code
    task automatic test_rate_mode();
        drain_results();
        reg_write(REG_PROB, 32'h1_0000);
        reg_write(REG_MIN_AMP, 32'hFFFF_8000);
        reg_write(REG_MAX_AMP, 32'h0000_7FFF);
        reg_write(REG_RST_LVL, 32'h0000_1234);
        reg_write(REG_RST_TICK, 32'd0);
        reg_write(REG_REFR, 32'd0);
        reg_write(REG_TSTEP, 32'd1);
        send_tick(32'd0, 16'hFFFF, 16'h0000);
        send_tick(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        send_item(ACT_UNUSED, $urandom, rand_isi(), 16'($urandom), 16'($urandom));
        send_reinit();      // pulls the last spike time back to zero
        drain_results();
        reg_write(REG_PROB, 32'h1_FFFF);     // above 1.0 saturates
        send_tick(32'd1, 16'hFFFF, 16'h8000);
        drain_results();
        reg_write(REG_PROB, 32'h0000_8000);  // strict compare at the boundary
        send_tick(32'd2, 16'h7FFF, 16'h1234);
        send_tick(32'd3, 16'h8000, 16'h1234);
        drain_results();
        reg_write(REG_PROB, 32'h1_0000);
        reg_write(REG_MIN_AMP, 32'd100);     // negative span rounds downwards
        reg_write(REG_MAX_AMP, 32'hFFFF_FF9C);
        send_tick(32'd4, 16'd0, 16'h0001);
        send_tick(32'd5, 16'd0, 16'hFFFF);
        drain_results();
        reg_write(REG_MIN_AMP, 32'd5);       // equal bounds
        reg_write(REG_MAX_AMP, 32'd5);
        send_tick(32'd6, 16'd0, 16'hABCD);
    endtask

    // interval mode window, huge and negative intervals, zero dt
    task automatic test_interval_mode();
        drain_results();
        reg_write(REG_TSTEP, 32'd4);
        reg_write(REG_PROB, 32'd0);
        reg_write(REG_MIN_AMP, 32'd0);
        reg_write(REG_MAX_AMP, 32'd1000);
        send_reinit();
        send_interval(33'sd10);
        send_tick(32'd5, 16'd0, 16'h4000);   // due time beyond the window
        send_tick(32'd7, 16'd0, 16'h4000);   // inside the window
        send_tick(32'd17, 16'd0, 16'hFFFF);  // exactly on time
        send_tick(32'd30, 16'd0, 16'h4000);  // overdue, no spike
        send_interval(33'h0_FFFF_FFFF);
        send_tick(32'd31, 16'd0, 16'h4000);
        send_interval(33'h1_FFFF_FFFF);      // back to rate mode
        send_tick(32'd32, 16'd0, 16'h4000);
        drain_results();
        reg_write(REG_TSTEP, 32'd0);         // empty window never fires
        send_interval(33'sd0);
        send_tick(32'd17, 16'd0, 16'h4000);
    endtask

    // refractory boundary and the widest refractory period
    task automatic test_refractory();
        drain_results();
        reg_write(REG_PROB, 32'h1_0000);
        reg_write(REG_TSTEP, 32'd1);
        reg_write(REG_REFR, 32'd100);
        send_reinit();
        send_tick(32'd0, 16'd0, 16'h1111);
        send_tick(32'd99, 16'd0, 16'h2222);
        send_tick(32'd100, 16'd0, 16'h3333);
        drain_results();
        reg_write(REG_REFR, 32'hFFFF_FFFF);
        send_reinit();
        send_tick(32'd5, 16'd0, 16'h4444);
        send_tick(32'd6, 16'd0, 16'h5555);
    endtask

    // level reload on every tick
    task automatic test_tick_reset();
        drain_results();
        reg_write(REG_RST_TICK, 32'd1);
        reg_write(REG_RST_LVL, 32'h0000_8000);
        reg_write(REG_PROB, 32'd0);
        send_tick(32'd7, 16'd0, 16'd0);
        drain_results();
        reg_write(REG_PROB, 32'h1_0000);
        reg_write(REG_REFR, 32'd0);
        send_reinit();
        send_tick(32'd10, 16'd0, 16'h9999);
        drain_results();
        reg_write(REG_RST_TICK, 32'd0);
    endtask

    task automatic load_random_settings();
        logic [16:0] prob;
        logic [15:0] lo_amp;
        logic [15:0] hi_amp;
        logic [15:0] dt;
        logic [31:0] refr;
        case ($urandom_range(0, 5))
            0:       prob = 17'd0;
            1:       prob = 17'h1_0000;
            2:       prob = 17'h1_FFFF;
            default: prob = 17'($urandom_range(0, 32'h1_0000));
        endcase
        lo_amp = 16'($urandom);
        hi_amp = ($urandom_range(0, 7) == 0) ? lo_amp : 16'($urandom);
        case ($urandom_range(0, 5))
            0, 1:    refr = 32'd0;
            2:       refr = $urandom;
            default: refr = $urandom_range(1, 300);
        endcase
        case ($urandom_range(0, 7))
            0:       dt = 16'd0;
            1:       dt = 16'hFFFF;
            default: dt = 16'($urandom_range(1, 64));
        endcase
        reg_write(REG_PROB, {15'd0, prob});
        reg_write(REG_MIN_AMP, {16'd0, lo_amp});
        reg_write(REG_MAX_AMP, {16'd0, hi_amp});
        reg_write(REG_RST_LVL, $urandom);
        reg_write(REG_RST_TICK, $urandom_range(0, 1));
        reg_write(REG_REFR, refr);
        reg_write(REG_TSTEP, {16'd0, dt});
    endtask

    // Mostly runs that start with a reinit (and often an interval load) and
    // then tick forward in time, so spikes, refractory gaps and window hits
    // actually happen; the rest is fully random noise on every field.
    task automatic random_phase(input int n_items);
        int stop_at;
        int pick;
        int step_max;
        longint t;
        longint isi_l;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                send_item(2'($urandom_range(0, 3)), $urandom, rand_isi(),
                          16'($urandom), 16'($urandom));
            end else begin
                send_reinit();
                if (pick < 60) begin
                    // first due time lands a little after time zero
                    isi_l = longint'({32'd0, refr_cfg}) + $urandom_range(0, 400);
                    if (isi_l > 64'sh0_FFFF_FFFF)
                        isi_l = 64'sh0_FFFF_FFFF;
                    send_interval({1'b0, isi_l[31:0]});
                    t = $urandom_range(0, 20);
                    step_max = (tstep_cfg == 16'd0) ? 40 : int'(tstep_cfg);
                end else begin
                    t = ($urandom_range(0, 3) == 0) ? longint'($urandom)
                                                    : longint'($urandom_range(0, 100));
                    step_max = 100;
                end
                repeat ($urandom_range(6, 30)) begin
                    if ($urandom_range(0, 19) == 0)
                        send_interval({1'b1, 32'($urandom)});
                    t += $urandom_range(1, step_max);
                    send_tick(t[31:0], 16'($urandom), 16'($urandom));
                end
            end
        end
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < PHASES; phase++) begin
            drain_results();
            load_random_settings();
            steady_flow <= (phase == 3);
            random_phase(PHASE_ITEMS);
        end
        steady_flow <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Result checker and receiver back-pressure
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_spike_res want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (spike_results_q.size() == 0) begin
                $display("%0t unexpected result: expected none actual fired %b time %h level %h",
                         $time, m_axis_tuser[0], m_axis_tdata[31:0], m_axis_tdata[47:32]);
                fail_count++;
            end else begin
                want = spike_results_q.pop_front();
                if (m_axis_tuser[0] !== want.fired) begin
                    $display("%0t fired: expected %b actual %b",
                             $time, want.fired, m_axis_tuser[0]);
                    fail_count++;
                end
                if (m_axis_tdata[31:0] !== want.event_time) begin
                    $display("%0t event_time: expected %h actual %h",
                             $time, want.event_time, m_axis_tdata[31:0]);
                    fail_count++;
                end
                if (m_axis_tdata[47:32] !== want.level) begin
                    $display("%0t level: expected %h actual %h",
                             $time, want.level, m_axis_tdata[47:32]);
                    fail_count++;
                end
            end
        end
        m_axis_tready <= steady_flow || ($urandom_range(0, 99) >= 30);
    end

    // watchdog: any transaction on either stream or the bus resets the count
    always @(posedge i_clk) begin
        if (!i_rst_n || psel || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t watchdog: no transaction for %0d cycles", $time, idle_cycles);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_register_defaults();
        test_rate_mode();
        test_interval_mode();
        test_refractory();
        test_tick_reset();
        test_random_traffic();
        drain_results();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
